@@ hw/rtl/iec_peak_hold_meter_defines.svh @@
// Assertion helpers used by the meter RTL.
`ifndef IEC_PEAK_HOLD_METER_DEFINES_SVH
`define IEC_PEAK_HOLD_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPHM_ASSERT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPHM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/iphm_pkg.sv @@
`default_nettype none
package iphm_pkg;

    localparam int CH_W    = 5;
    localparam int LEVEL_W = 16;
    localparam int BAR_W   = 9;
    localparam int TIMER_W = 16;
    localparam int DEFL_W  = 13;
    localparam int CFG_W   = 16;

    localparam int DEFAULT_CHANNELS = 32;
    localparam int MAX_BAR_WIDTH    = 256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // floor(x / 25) == (x * 5243) >> 17 for every x below 43690.
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    localparam logic [BAR_W-1:0]   BAR_WIDTH_RESET  = 9'd64;
    localparam logic [TIMER_W-1:0] HOLD_DECAY_RESET = 16'd16;
    localparam logic [TIMER_W-1:0] TIMER_MAX        = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [0:0] CFG_BAR_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HOLD_DECAY = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [BAR_W-1:0] bar_in;
        logic [BAR_W-1:0] bar_out;
    } t_bar_word;

    typedef struct packed {
        logic [BAR_W-1:0]   hold;
        logic [BAR_W-1:0]   max;
        logic [TIMER_W-1:0] timer;
    } t_chan_state;

endpackage
`default_nettype wire

@@ hw/rtl/iphm_ram.sv @@
`default_nettype none
module iphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ hw/rtl/iphm_front.sv @@
`default_nettype none
module iphm_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [iphm_pkg::CH_W-1:0]           i_channel,
    input  wire logic signed [iphm_pkg::LEVEL_W-1:0] i_level_in_db,
    input  wire logic signed [iphm_pkg::LEVEL_W-1:0] i_level_out_db,
    input  wire logic [iphm_pkg::BAR_W-1:0]          i_width,
    input  wire logic [iphm_pkg::QCNT_W-1:0]         i_queue_count,
    output logic                                     o_push,
    output iphm_pkg::t_bar_word                      o_push_word
);
    import iphm_pkg::*;

    // Piecewise-linear IEC deflection in 1/64 percent.
    function automatic logic [DEFL_W-1:0] deflection(input logic signed [LEVEL_W-1:0] lvl);
        logic signed [LEVEL_W:0] l17;
        logic [DEFL_W-1:0]       d;
        l17 = {lvl[LEVEL_W-1], lvl};
        if (lvl < -16'sd1120) begin
            d = '0;
        end else if (lvl < -16'sd960) begin
            d = DEFL_W'(l17 + 17'sd1120);
        end else if (lvl < -16'sd800) begin
            d = DEFL_W'((l17 + 17'sd960) * 17'sd2 + 17'sd160);
        end else if (lvl < -16'sd640) begin
            d = DEFL_W'((l17 + 17'sd800) * 17'sd3 + 17'sd480);
        end else if (lvl < -16'sd480) begin
            d = DEFL_W'((l17 + 17'sd640) * 17'sd6 + 17'sd960);
        end else if (lvl < -16'sd320) begin
            d = DEFL_W'((l17 + 17'sd480) * 17'sd8 + 17'sd1920);
        end else if (lvl < 16'sd0) begin
            d = DEFL_W'((l17 + 17'sd320) * 17'sd10 + 17'sd3200);
        end else begin
            d = 13'd6400;
        end
        return d;
    endfunction

    // Stage A: deflection. Stage B: deflection times width, divided by 256.
    logic                r_a_valid;
    logic [CH_W-1:0]     r_a_ch;
    logic [DEFL_W-1:0]   r_a_din;
    logic [DEFL_W-1:0]   r_a_dout;
    logic                r_b_valid;
    logic [CH_W-1:0]     r_b_ch;
    logic [13:0]         r_b_xin;
    logic [13:0]         r_b_xout;

    logic [21:0] prod_in;
    logic [21:0] prod_out;
    logic [26:0] quot_in;
    logic [26:0] quot_out;
    logic [QCNT_W:0] credit_used;
    logic            accept;

    // Items in flight count against queue space, so the pipeline never stalls.
    assign credit_used = (QCNT_W+1)'(i_queue_count) + (QCNT_W+1)'(r_a_valid)
                       + (QCNT_W+1)'(r_b_valid);
    assign o_in_ready  = credit_used < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept      = i_in_valid && o_in_ready;

    assign prod_in  = 22'(r_a_din) * 22'(i_width);
    assign prod_out = 22'(r_a_dout) * 22'(i_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
        end
        r_a_ch   <= i_channel;
        r_a_din  <= deflection(i_level_in_db);
        r_a_dout <= deflection(i_level_out_db);
        r_b_ch   <= r_a_ch;
        r_b_xin  <= prod_in[21:8];
        r_b_xout <= prod_out[21:8];
    end

    assign quot_in  = 27'(r_b_xin) * 27'(RECIP_25);
    assign quot_out = 27'(r_b_xout) * 27'(RECIP_25);

    assign o_push              = r_b_valid;
    assign o_push_word.channel = r_b_ch;
    assign o_push_word.bar_in  = quot_in[RECIP_SHIFT +: BAR_W];
    assign o_push_word.bar_out = quot_out[RECIP_SHIFT +: BAR_W];
endmodule
`default_nettype wire

@@ hw/rtl/iphm_queue.sv @@
`default_nettype none
module iphm_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire iphm_pkg::t_bar_word         i_push_word,
    input  wire logic                        i_pop,
    output iphm_pkg::t_bar_word              o_head,
    output logic                             o_not_empty,
    output logic [iphm_pkg::QCNT_W-1:0]      o_count
);
    import iphm_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    t_bar_word         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_push_word;
        end
    end

    assign o_head      = r_mem[r_rptr];
    assign o_not_empty = r_count != '0;
    assign o_count     = r_count;
endmodule
`default_nettype wire

@@ hw/rtl/iphm_back.sv @@
`default_nettype none
`include "iec_peak_hold_meter_defines.svh"
module iphm_back #(
    parameter int CHANNELS = iphm_pkg::DEFAULT_CHANNELS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire iphm_pkg::t_bar_word           i_head,
    input  wire logic                          i_not_empty,
    output logic                               o_pop,
    input  wire logic [iphm_pkg::BAR_W-1:0]    i_width,
    input  wire logic [iphm_pkg::TIMER_W-1:0]  i_decay,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [iphm_pkg::CH_W-1:0]          o_channel_echo,
    output logic [iphm_pkg::BAR_W-1:0]         o_in_bar_length,
    output logic [iphm_pkg::BAR_W-1:0]         o_out_bar_length,
    output logic [iphm_pkg::BAR_W-1:0]         o_hold_length,
    output logic [iphm_pkg::BAR_W-1:0]         o_max_length,
    output logic                               o_near_full_scale
);
    import iphm_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW = $bits(t_chan_state);

    localparam logic [0:0] ST_IDLE   = 1'b0;
    localparam logic [0:0] ST_UPDATE = 1'b1;

    logic [0:0]          r_state;
    logic [0:0]          n_state;
    t_bar_word           r_work;
    logic                r_rd_valid;
    logic [CHANNELS-1:0] r_valid;

    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_ch;
    logic [BAR_W-1:0]   r_out_bin;
    logic [BAR_W-1:0]   r_out_bout;
    logic [BAR_W-1:0]   r_out_hold;
    logic [BAR_W-1:0]   r_out_max;
    logic               r_out_near;

    logic [AW-1:0] head_addr;
    logic [AW-1:0] work_addr;
    logic          head_in_range;
    logic          work_in_range;
    logic [SW-1:0] rdata;
    t_chan_state   cur;
    t_chan_state   upd;
    logic          do_write;
    logic [9:0]    max_plus2;
    logic          near;

    assign head_addr     = AW'(i_head.channel);
    assign work_addr     = AW'(r_work.channel);
    assign head_in_range = 32'(i_head.channel) < 32'(CHANNELS);
    assign work_in_range = 32'(r_work.channel) < 32'(CHANNELS);

    // The output register is free at the update whenever an item is popped.
    assign o_pop = (r_state == ST_IDLE) && i_not_empty && (!r_out_valid || i_out_ready);

    iphm_ram #(
        .WIDTH (SW),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (work_addr),
        .i_wdata (upd),
        .i_re    (o_pop),
        .i_raddr (head_addr),
        .o_rdata (rdata)
    );

    // A channel never written since reset reads as all zero.
    assign cur = r_rd_valid ? t_chan_state'(rdata) : '0;

    always_comb begin
        upd = cur;
        if (r_work.bar_in > cur.max) begin
            upd.max = r_work.bar_in;
        end
        if (r_work.bar_in > cur.hold) begin
            upd.hold  = r_work.bar_in;
            upd.timer = '0;
        end else begin
            if (cur.timer > i_decay) begin
                upd.hold = r_work.bar_in;
            end
            if (cur.timer != TIMER_MAX) begin
                upd.timer = cur.timer + 1'b1;
            end
        end
    end

    assign do_write  = (r_state == ST_UPDATE) && work_in_range;
    assign max_plus2 = {1'b0, upd.max} + 10'd2;
    assign near      = max_plus2 > {1'b0, i_width};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (o_pop) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_write) begin
                r_valid[work_addr] <= 1'b1;
            end
            if (r_state == ST_UPDATE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_work     <= i_head;
            r_rd_valid <= head_in_range && r_valid[head_addr];
        end
        if (r_state == ST_UPDATE) begin
            r_out_ch   <= r_work.channel;
            r_out_bin  <= r_work.bar_in;
            r_out_bout <= r_work.bar_out;
            r_out_hold <= work_in_range ? upd.hold : '0;
            r_out_max  <= work_in_range ? upd.max : '0;
            r_out_near <= work_in_range && near;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_channel_echo    = r_out_ch;
    assign o_in_bar_length   = r_out_bin;
    assign o_out_bar_length  = r_out_bout;
    assign o_hold_length     = r_out_hold;
    assign o_max_length      = r_out_max;
    assign o_near_full_scale = r_out_near;

    `IPHM_ASSERT(a_update_out_free, i_clk, i_rst_n, r_state == ST_UPDATE, !r_out_valid, "update while output register busy")
    `IPHM_ASSERT_NEXT(a_update_loads, i_clk, i_rst_n, r_state == ST_UPDATE, r_state == ST_IDLE && r_out_valid, "update did not load a result")
    `IPHM_ASSERT(a_hold_below_max, i_clk, i_rst_n, r_out_valid, r_out_hold <= r_out_max, "hold above all-time maximum")
    `IPHM_ASSERT(a_unused_channel, i_clk, i_rst_n, r_out_valid && 32'(r_out_ch) >= 32'(CHANNELS), r_out_hold == '0 && r_out_max == '0 && !r_out_near, "state shown for unused channel")
endmodule
`default_nettype wire

@@ hw/rtl/iec_peak_hold_meter.sv @@
`default_nettype none
// Channel  Handshake                 Word
// input    i_in_valid / o_in_ready   i_channel, i_level_in_db, i_level_out_db
// result   o_out_valid / i_out_ready o_channel_echo, o_*_length, o_near_full_scale
// config   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An accepted word passes two scaling stages into the queue; its pop does the registered
// state read, and the next cycle updates the state and loads the result register.
// The back end pops no new word before the read-then-write on the state RAM for the
// last one is done, nor while a held result fills the output register.
// Reset is synchronous; per-channel valid bits clear at once, so no clearing pass.
// Up to four words may wait behind a held result; then input ready drops.
module iec_peak_hold_meter #(
    parameter int CHANNELS = iphm_pkg::DEFAULT_CHANNELS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [iphm_pkg::CH_W-1:0]           i_channel,
    input  wire logic signed [iphm_pkg::LEVEL_W-1:0] i_level_in_db,
    input  wire logic signed [iphm_pkg::LEVEL_W-1:0] i_level_out_db,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [iphm_pkg::CH_W-1:0]                o_channel_echo,
    output logic [iphm_pkg::BAR_W-1:0]               o_in_bar_length,
    output logic [iphm_pkg::BAR_W-1:0]               o_out_bar_length,
    output logic [iphm_pkg::BAR_W-1:0]               o_hold_length,
    output logic [iphm_pkg::BAR_W-1:0]               o_max_length,
    output logic                                     o_near_full_scale,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [0:0]                          i_cfg_index,
    input  wire logic [iphm_pkg::CFG_W-1:0]          i_cfg_data
);
    import iphm_pkg::*;

    logic [BAR_W-1:0]   r_bar_width;
    logic [TIMER_W-1:0] r_hold_decay;
    logic [BAR_W-1:0]   width_eff;

    logic              push;
    t_bar_word         push_word;
    logic              pop;
    t_bar_word         head;
    logic              not_empty;
    logic [QCNT_W-1:0] queue_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_width  <= BAR_WIDTH_RESET;
            r_hold_decay <= HOLD_DECAY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BAR_WIDTH:  r_bar_width  <= i_cfg_data[BAR_W-1:0];
                CFG_HOLD_DECAY: r_hold_decay <= i_cfg_data[TIMER_W-1:0];
                default:        ;
            endcase
        end
    end

    assign width_eff = (r_bar_width > BAR_W'(MAX_BAR_WIDTH)) ? BAR_W'(MAX_BAR_WIDTH)
                                                             : r_bar_width;

    iphm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_channel      (i_channel),
        .i_level_in_db  (i_level_in_db),
        .i_level_out_db (i_level_out_db),
        .i_width        (width_eff),
        .i_queue_count  (queue_count),
        .o_push         (push),
        .o_push_word    (push_word)
    );

    iphm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (not_empty),
        .o_count     (queue_count)
    );

    iphm_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .i_not_empty       (not_empty),
        .o_pop             (pop),
        .i_width           (width_eff),
        .i_decay           (r_hold_decay),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_channel_echo    (o_channel_echo),
        .o_in_bar_length   (o_in_bar_length),
        .o_out_bar_length  (o_out_bar_length),
        .o_hold_length     (o_hold_length),
        .o_max_length      (o_max_length),
        .o_near_full_scale (o_near_full_scale)
    );
endmodule
`default_nettype wire
